@@ sv/sliding_window_minimum_macros.svh @@
// Assertion helpers used by the checker file of this block.
`ifndef SLIDING_WINDOW_MINIMUM_MACROS_SVH
`define SLIDING_WINDOW_MINIMUM_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is low.
`define SWM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sliding window minimum check failed");

// Implication to the next cycle, built on the helper above.
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`SWM_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ sv/swm_pkg.sv @@
package swm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int WLEN_W = 9;
	localparam int DEFAULT_MAX_WINDOW = 256;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} swm_state_t;

	// Controls broadcast to every cell of the chain.
	typedef struct packed {
		logic shift;
		logic prop;
	} swm_cell_ctrl_t;

endpackage

@@ sv/swm_cell.sv @@
module swm_cell import swm_pkg::*; #(
	parameter int CNT_W = 9,
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  swm_cell_ctrl_t             ctrl,
	input  logic [CNT_W-1:0]           len,
	input  logic signed [SAMPLE_W-1:0] v_in,
	input  logic signed [SAMPLE_W-1:0] m_next,
	output logic signed [SAMPLE_W-1:0] v_out,
	output logic signed [SAMPLE_W-1:0] m_out
);

	logic signed [SAMPLE_W-1:0] v_q;
	logic signed [SAMPLE_W-1:0] m_q;
	logic                       active;

	// Cells beyond the window start at the largest value so they never win.
	assign active = CNT_W'(IDX) < len;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			v_q <= v_in;
			m_q <= active ? v_in : SAMPLE_MAX;
		end else if (ctrl.prop) begin
			if (m_next < m_q) begin
				m_q <= m_next;
			end
		end
	end

	assign v_out = v_q;
	assign m_out = m_q;

endmodule

@@ sv/sliding_window_minimum.sv @@
// Channel        | Handshake                  | Payload
// ---------------+----------------------------+------------------------------
// sample in      | s_tvalid / s_tready        | s_tdata[31:0] = sample
// minimum out    | m_tvalid / m_tready        | m_tdata[31:0] = window_min
// window length  | window_length_we           | window_length_wdata[8:0]
//
// An item that yields no result is only shifted into the chain. An item that
// yields a result is shifted in, then the running minimum walks down the
// chain one cell per step over the L cells of the effective window, and at
// the end the output register is loaded. s_tready is low during the scan.
// Reset clears the fill count, the controller and the output valid, and sets the length to 1.
// A stalled output holds its result; a finished scan waits for the register.
module sliding_window_minimum import swm_pkg::*; #(
	parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                window_length_we,
	input  logic [WLEN_W-1:0]   window_length_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata    // [31:0] window_min
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

	swm_state_t                 state_q, state_d;
	logic [WLEN_W-1:0]          wlen_q;
	logic [CNT_W-1:0]           fill_q, fill_d;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [CNT_W-1:0]           len_eff;
	logic [CMP_W-1:0]           wlen_ext;
	logic                       out_load;
	logic                       m_tvalid_q;
	logic [SAMPLE_W-1:0]        m_tdata_q;
	swm_cell_ctrl_t             ctrl;
	logic signed [SAMPLE_W-1:0] v_w [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] m_w [MAX_WINDOW];

	assign wlen_ext = CMP_W'(wlen_q);

	always_comb begin
		if (wlen_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
			len_eff = CNT_W'(MAX_WINDOW);
		end else begin
			len_eff = CNT_W'(wlen_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (window_length_we) begin
			wlen_q <= window_length_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		count_d    = count_q;
		s_tready   = 1'b0;
		out_load   = 1'b0;
		ctrl.shift = 1'b0;
		ctrl.prop  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.shift = 1'b1;
					if (fill_q != CNT_W'(MAX_WINDOW)) begin
						fill_d = fill_q + CNT_W'(1);
					end
					if (fill_d >= len_eff) begin
						state_d = ST_SCAN;
						count_d = len_eff - CNT_W'(1);
					end
				end
			end
			ST_SCAN: begin
				if (count_q != '0) begin
					ctrl.prop = 1'b1;
					count_d   = count_q - CNT_W'(1);
				end else if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [SAMPLE_W-1:0] v_in;
		logic signed [SAMPLE_W-1:0] m_next;

		if (i == 0) begin : g_head
			assign v_in = $signed(s_tdata);
		end else begin : g_body
			assign v_in = v_w[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_tail
			assign m_next = SAMPLE_MAX;
		end else begin : g_link
			assign m_next = m_w[i+1];
		end

		swm_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.len    (len_eff),
			.v_in   (v_in),
			.m_next (m_next),
			.v_out  (v_w[i]),
			.m_out  (m_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= m_w[0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ sv/swm_checker.sv @@
`include "sliding_window_minimum_macros.svh"

module swm_port_checks import swm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                window_length_we,
	input logic [WLEN_W-1:0]   window_length_wdata,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [SAMPLE_W-1:0] s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [SAMPLE_W-1:0] m_tdata
);

	logic [SAMPLE_W-1:0] last_q;

	// The newest sample is always inside the window, so no fresh minimum exceeds it.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			last_q <= s_tdata;
		end
	end

	`SWM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`SWM_ASSERT(a_load_while_busy, clk, arst_n, $rose(m_tvalid) |-> $past(!s_tready))
	`SWM_ASSERT(a_min_bound, clk, arst_n, $rose(m_tvalid) |-> $signed(m_tdata) <= $signed(last_q))
	`SWM_ASSERT_NEXT(a_no_instant_result, clk, arst_n, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

bind sliding_window_minimum swm_port_checks u_swm_checker (.*);
